// ----- rtl/escape_time_fractal_iterator_macros.svh -----
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define EFTI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("efti check failed");

// Next-cycle implication, disabled while in reset
`define EFTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("efti check failed");

`endif

// ----- rtl/efti_pkg.sv -----
package efti_pkg;

  localparam int IMAGE_WIDTH  = 1024;
  localparam int IMAGE_HEIGHT = 1024;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int Q_W        = 32;
  localparam int STEP_W     = 31;
  localparam int ITER_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = 64;
  localparam int ACC_W      = 44;
  localparam int FRAC_BITS  = 28;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_HEIGHT - 1);

  // 4.0 with 56 fraction bits
  localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(64'h0400_0000_0000_0000);

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_REAL    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_IMAG       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_STEP_REAL      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_STEP_IMAG      = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_C_REAL   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_C_IMAG   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_FRACTAL_MODE   = CFG_IDX_W'(7);

  localparam logic MODE_MANDELBROT = 1'b0;
  localparam logic MODE_JULIA      = 1'b1;

  typedef struct packed {
    logic signed [Q_W-1:0] origin_real;
    logic signed [Q_W-1:0] top_imag;
    logic [STEP_W-1:0]     step_real;
    logic [STEP_W-1:0]     step_imag;
    logic signed [Q_W-1:0] julia_c_real;
    logic signed [Q_W-1:0] julia_c_imag;
    logic [ITER_W-1:0]     max_iterations;
    logic                  fractal_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    origin_real:    32'hE000_0000,
    top_imag:       32'h2000_0000,
    step_real:      31'h0010_0000,
    step_imag:      31'h0010_0000,
    julia_c_real:   32'h0000_0000,
    julia_c_imag:   32'h0000_0000,
    max_iterations: 16'd64,
    fractal_mode:   MODE_MANDELBROT
  };

  // Clip a wide signed sum to the Q4.28 range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
    logic hi_zero;
    logic hi_ones;
    hi_zero = (v[ACC_W-1:Q_W-1] == '0);
    hi_ones = (v[ACC_W-1:Q_W-1] == '1);
    if (hi_zero || hi_ones) begin
      sat_q = v[Q_W-1:0];
    end else if (v[ACC_W-1]) begin
      sat_q = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      sat_q = {1'b0, {(Q_W-1){1'b1}}};
    end
  endfunction

endpackage

// ----- rtl/efti_in_if.sv -----
interface efti_in_if;
  logic                        valid;
  logic                        ready;
  logic [efti_pkg::COL_W-1:0] pixel_col;
  logic [efti_pkg::ROW_W-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

// ----- rtl/efti_out_if.sv -----
interface efti_out_if;
  logic                         valid;
  logic                         ready;
  logic [efti_pkg::ITER_W-1:0] iteration_count;
  logic                         escaped;

  modport source (output valid, output iteration_count, output escaped, input ready);
  modport sink (input valid, input iteration_count, input escaped, output ready);
endinterface

// ----- rtl/efti_cfg_if.sv -----
interface efti_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [efti_pkg::CFG_IDX_W-1:0]  index;
  logic [efti_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/efti_mul.sv -----
module efti_mul (
  input  logic                                clk,
  input  logic signed [efti_pkg::Q_W-1:0]    a,
  input  logic signed [efti_pkg::Q_W-1:0]    b,
  output logic signed [efti_pkg::PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

// ----- rtl/efti_regs.sv -----
module efti_regs (
  input  logic           clk,
  input  logic           rst_n,
  efti_cfg_if.sink       cfg_s,
  output efti_pkg::cfg_t cfg
);

  efti_pkg::cfg_t cfg_r;
  efti_pkg::cfg_t cfg_nxt;

  assign cfg_s.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_s.valid) begin
      unique case (cfg_s.index)
        efti_pkg::REG_ORIGIN_REAL:    cfg_nxt.origin_real    = cfg_s.data[efti_pkg::Q_W-1:0];
        efti_pkg::REG_TOP_IMAG:       cfg_nxt.top_imag       = cfg_s.data[efti_pkg::Q_W-1:0];
        efti_pkg::REG_STEP_REAL:      cfg_nxt.step_real      = cfg_s.data[efti_pkg::STEP_W-1:0];
        efti_pkg::REG_STEP_IMAG:      cfg_nxt.step_imag      = cfg_s.data[efti_pkg::STEP_W-1:0];
        efti_pkg::REG_JULIA_C_REAL:   cfg_nxt.julia_c_real   = cfg_s.data[efti_pkg::Q_W-1:0];
        efti_pkg::REG_JULIA_C_IMAG:   cfg_nxt.julia_c_imag   = cfg_s.data[efti_pkg::Q_W-1:0];
        efti_pkg::REG_MAX_ITERATIONS: cfg_nxt.max_iterations = cfg_s.data[efti_pkg::ITER_W-1:0];
        efti_pkg::REG_FRACTAL_MODE:   cfg_nxt.fractal_mode   = cfg_s.data[0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= efti_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/efti_core.sv -----
module efti_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  efti_pkg::cfg_t                      cfg,
  efti_in_if.sink                             in_s,
  efti_out_if.source                          out_m,
  output logic signed [efti_pkg::Q_W-1:0]    mul_a,
  output logic signed [efti_pkg::Q_W-1:0]    mul_b,
  input  logic signed [efti_pkg::PROD_W-1:0] mul_p
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_R,
    S_MAP_I,
    S_MAP_END,
    S_RR,
    S_II,
    S_RI,
    S_EVAL,
    S_DONE
  } state_t;

  localparam int QW = efti_pkg::Q_W;
  localparam int AW = efti_pkg::ACC_W;
  localparam int PW = efti_pkg::PROD_W;

  state_t state_r, state_nxt;
  logic [efti_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [efti_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic signed [QW-1:0]        zr_r, zr_nxt;
  logic signed [QW-1:0]        zi_r, zi_nxt;
  logic signed [QW-1:0]        cr_r, cr_nxt;
  logic signed [QW-1:0]        ci_r, ci_nxt;
  logic [efti_pkg::ITER_W-1:0] count_r, count_nxt;
  logic signed [PW-1:0]        rr_r, rr_nxt;
  logic signed [PW-1:0]        diff_r, diff_nxt;
  logic                        esc_r, esc_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [efti_pkg::ITER_W-1:0] out_count_r, out_count_nxt;
  logic                        out_esc_r, out_esc_nxt;

  logic signed [AW-1:0] orig_ext, top_ext, cr_ext, ci_ext, prod_lo;
  logic signed [AW-1:0] map_re, map_im, diff_lo, ri_lo, nr_sum, ni_sum;
  logic signed [PW-1:0] diff_sh, ri_sh;
  logic [PW-1:0]        mag;
  logic signed [QW-1:0] zi_mapped;

  assign in_s.ready            = (state_r == S_IDLE);
  assign out_m.valid           = out_valid_r;
  assign out_m.iteration_count = out_count_r;
  assign out_m.escaped         = out_esc_r;

  assign orig_ext = {{(AW-QW){cfg.origin_real[QW-1]}}, cfg.origin_real};
  assign top_ext  = {{(AW-QW){cfg.top_imag[QW-1]}}, cfg.top_imag};
  assign cr_ext   = {{(AW-QW){cr_r[QW-1]}}, cr_r};
  assign ci_ext   = {{(AW-QW){ci_r[QW-1]}}, ci_r};
  // mapping products are non-negative and well inside the accumulator width
  assign prod_lo  = mul_p[AW-1:0];
  assign map_re   = orig_ext + prod_lo;
  assign map_im   = top_ext - prod_lo;
  assign zi_mapped = efti_pkg::sat_q(map_im);

  // arithmetic shifts give the floor of the scaled products
  assign diff_sh = diff_r >>> efti_pkg::FRAC_BITS;
  assign ri_sh   = mul_p >>> (efti_pkg::FRAC_BITS - 1);
  assign diff_lo = diff_sh[AW-1:0];
  assign ri_lo   = ri_sh[AW-1:0];
  assign nr_sum  = diff_lo + cr_ext;
  assign ni_sum  = ri_lo + ci_ext;

  // squares are non-negative, so the exact sum fits unsigned
  assign mag = $unsigned(rr_r) + $unsigned(mul_p);

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    count_nxt     = count_r;
    rr_nxt        = rr_r;
    diff_nxt      = diff_r;
    esc_nxt       = esc_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_esc_nxt   = out_esc_r;
    mul_a         = zr_r;
    mul_b         = zi_r;

    if (out_valid_r && out_m.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_s.valid) begin
          col_nxt = (32'(in_s.pixel_col) > 32'(efti_pkg::IMAGE_WIDTH - 1)) ?
                    efti_pkg::COL_LAST : in_s.pixel_col;
          row_nxt = (32'(in_s.pixel_row) > 32'(efti_pkg::IMAGE_HEIGHT - 1)) ?
                    efti_pkg::ROW_LAST : in_s.pixel_row;
          state_nxt = S_MAP_R;
        end
      end
      S_MAP_R: begin
        mul_a     = {{(QW-efti_pkg::COL_W){1'b0}}, col_r};
        mul_b     = {1'b0, cfg.step_real};
        state_nxt = S_MAP_I;
      end
      S_MAP_I: begin
        mul_a     = {{(QW-efti_pkg::ROW_W){1'b0}}, row_r};
        mul_b     = {1'b0, cfg.step_imag};
        zr_nxt    = efti_pkg::sat_q(map_re);
        state_nxt = S_MAP_END;
      end
      S_MAP_END: begin
        zi_nxt    = zi_mapped;
        cr_nxt    = (cfg.fractal_mode == efti_pkg::MODE_JULIA) ? cfg.julia_c_real : zr_r;
        ci_nxt    = (cfg.fractal_mode == efti_pkg::MODE_JULIA) ? cfg.julia_c_imag : zi_mapped;
        count_nxt = '0;
        state_nxt = S_RR;
      end
      S_RR: begin
        mul_a     = zr_r;
        mul_b     = zr_r;
        state_nxt = S_II;
      end
      S_II: begin
        mul_a     = zi_r;
        mul_b     = zi_r;
        rr_nxt    = mul_p;
        state_nxt = S_RI;
      end
      S_RI: begin
        // mul_p holds zi^2 here
        mul_a     = zr_r;
        mul_b     = zi_r;
        esc_nxt   = (mag > efti_pkg::ESC_LIMIT);
        diff_nxt  = rr_r - mul_p;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // mul_p holds zr*zi here
        if (esc_r || (count_r >= cfg.max_iterations)) begin
          state_nxt = S_DONE;
        end else begin
          zr_nxt    = efti_pkg::sat_q(nr_sum);
          zi_nxt    = efti_pkg::sat_q(ni_sum);
          count_nxt = count_r + 1'b1;
          state_nxt = S_RR;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_m.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          out_esc_nxt   = esc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      zr_r        <= zr_nxt;
      zi_r        <= zi_nxt;
      cr_r        <= cr_nxt;
      ci_r        <= ci_nxt;
      count_r     <= count_nxt;
      rr_r        <= rr_nxt;
      diff_r      <= diff_nxt;
      esc_r       <= esc_nxt;
      out_count_r <= out_count_nxt;
      out_esc_r   <= out_esc_nxt;
    end
  end

endmodule

// ----- rtl/escape_time_fractal_iterator.sv -----
// Each input pixel is mapped (S_MAP_R, S_MAP_I, S_MAP_END), then iterated until escape or the limit.
// One shared 32x32 multiplier serves the two mapping products and three
// products per iteration, and a sequencer steps them plus an evaluate state.
// Input is not ready while a pixel is in flight; a finished result waits in the output register.
// Reset (rst_n low, synchronous): sequencer idle, output empty, registers to defaults.
module escape_time_fractal_iterator (
  input  logic       clk,
  input  logic       rst_n,
  efti_in_if.sink    in_s,
  efti_out_if.source out_m,
  efti_cfg_if.sink   cfg_s
);

  efti_pkg::cfg_t                      cfg;
  logic signed [efti_pkg::Q_W-1:0]    mul_a;
  logic signed [efti_pkg::Q_W-1:0]    mul_b;
  logic signed [efti_pkg::PROD_W-1:0] mul_p;

  efti_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_s (cfg_s),
    .cfg   (cfg)
  );

  efti_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .in_s  (in_s),
    .out_m (out_m),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  efti_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (mul_p)
  );

endmodule

// ----- rtl/efti_checker.sv -----
`include "escape_time_fractal_iterator_macros.svh"

module efti_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [efti_pkg::ITER_W-1:0] out_count,
  input logic                         out_esc
);

  // a stalled result stays offered and unchanged
  `EFTI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `EFTI_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_count) && $stable(out_esc))

  // a pixel in flight blocks the input; an idle block stays ready
  `EFTI_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `EFTI_ASSERT_NEXT(a_idle_holds, clk, rst_n, in_ready && !in_valid, in_ready)

endmodule

bind escape_time_fractal_iterator efti_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_count (out_m.iteration_count),
  .out_esc   (out_m.escaped)
);

// ----- test/escape_time_fractal_iterator_checker.sv -----
`timescale 1ns / 1ps

module escape_time_fractal_iterator_checker (
  input  logic clk,
  input  logic rst_n,
  efti_in_if   in_if,
  efti_out_if  out_if,
  efti_cfg_if  cfg_if,
  output int   mismatches,
  output int   results_seen
);
  import efti_pkg::*;

  localparam int          Q_FRAC = 28;
  localparam longint      Q_MAX  = 64'sd2147483647;
  localparam longint      Q_MIN  = -64'sd2147483648;
  localparam logic [63:0] ESCAPE_RADIUS_SQ = 64'h0400_0000_0000_0000;

  localparam cfg_t VIEW_AT_RESET = '{
    origin_real:    32'hE000_0000,
    top_imag:       32'h2000_0000,
    step_real:      31'h0010_0000,
    step_imag:      31'h0010_0000,
    julia_c_real:   32'h0000_0000,
    julia_c_imag:   32'h0000_0000,
    max_iterations: 16'd64,
    fractal_mode:   MODE_MANDELBROT
  };

  typedef struct packed {
    logic [ITER_W-1:0] count;
    logic              escaped;
  } escape_result_t;

  cfg_t           view;
  escape_result_t pending_results[$];

  function automatic logic signed [Q_W-1:0] clip_q(input longint v);
    if (v > Q_MAX) return Q_MAX[Q_W-1:0];
    if (v < Q_MIN) return Q_MIN[Q_W-1:0];
    return v[Q_W-1:0];
  endfunction

  // Map the pixel into the plane and run z = z*z + c until escape or limit
  function automatic escape_result_t escape_time(input cfg_t v,
                                                 input logic [COL_W-1:0] pixel_col,
                                                 input logic [ROW_W-1:0] pixel_row);
    longint                col;
    longint                row;
    longint                rr;
    longint                ii;
    longint                ri;
    logic [63:0]           mag;
    logic signed [Q_W-1:0] cr;
    logic signed [Q_W-1:0] ci;
    logic signed [Q_W-1:0] zr;
    logic signed [Q_W-1:0] zi;
    int unsigned           iters;
    bit                    done;
    escape_result_t        res;
    col = longint'(pixel_col);
    row = longint'(pixel_row);
    if (col > IMAGE_WIDTH - 1) col = IMAGE_WIDTH - 1;
    if (row > IMAGE_HEIGHT - 1) row = IMAGE_HEIGHT - 1;
    zr = clip_q(longint'(v.origin_real) + col * longint'(v.step_real));
    zi = clip_q(longint'(v.top_imag) - row * longint'(v.step_imag));
    if (v.fractal_mode == MODE_JULIA) begin
      cr = v.julia_c_real;
      ci = v.julia_c_imag;
    end else begin
      cr = zr;
      ci = zi;
    end
    iters = 0;
    res.escaped = 1'b0;
    done = 1'b0;
    while (!done) begin
      rr = longint'(zr) * longint'(zr);
      ii = longint'(zi) * longint'(zi);
      ri = longint'(zr) * longint'(zi);
      // both squares are non-negative, so the unsigned sum is exact
      mag = rr + ii;
      if (mag > ESCAPE_RADIUS_SQ) begin
        res.escaped = 1'b1;
        done = 1'b1;
      end else if (iters >= v.max_iterations) begin
        done = 1'b1;
      end else begin
        zr = clip_q(((rr - ii) >>> Q_FRAC) + longint'(cr));
        zi = clip_q((ri >>> (Q_FRAC - 1)) + longint'(ci));
        iters++;
      end
    end
    res.count = ITER_W'(iters);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    escape_result_t want;
    if (!rst_n) begin
      view = VIEW_AT_RESET;
      pending_results.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_ORIGIN_REAL:    view.origin_real = cfg_if.data;
          REG_TOP_IMAG:       view.top_imag = cfg_if.data;
          REG_STEP_REAL:      view.step_real = cfg_if.data[STEP_W-1:0];
          REG_STEP_IMAG:      view.step_imag = cfg_if.data[STEP_W-1:0];
          REG_JULIA_C_REAL:   view.julia_c_real = cfg_if.data;
          REG_JULIA_C_IMAG:   view.julia_c_imag = cfg_if.data;
          REG_MAX_ITERATIONS: view.max_iterations = cfg_if.data[ITER_W-1:0];
          REG_FRACTAL_MODE:   view.fractal_mode = cfg_if.data[0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready)
        pending_results.push_back(escape_time(view, in_if.pixel_col, in_if.pixel_row));
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transaction: count %0d, escaped %0b",
                   $time, out_if.iteration_count, out_if.escaped);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_if.iteration_count !== want.count) begin
            $display("%0t: iteration_count mismatch: expected %0d, actual %0d",
                     $time, want.count, out_if.iteration_count);
            mismatches++;
          end
          if (out_if.escaped !== want.escaped) begin
            $display("%0t: escaped mismatch: expected %0b, actual %0b",
                     $time, want.escaped, out_if.escaped);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

// ----- test/escape_time_fractal_iterator_tb.sv -----
`timescale 1ns / 1ps

module escape_time_fractal_iterator_tb;
  import efti_pkg::*;

  localparam int TOTAL_PIXELS   = 650;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 100;
  localparam int WATCHDOG_LIMIT = 1_000_000;

  typedef enum int {VIEW_ZOOM, VIEW_WILD, VIEW_OUTSIDE} view_kind_t;

  localparam cfg_t HOME_VIEW = '{
    origin_real:    32'hE000_0000,
    top_imag:       32'h2000_0000,
    step_real:      31'h0010_0000,
    step_imag:      31'h0010_0000,
    julia_c_real:   32'h0000_0000,
    julia_c_imag:   32'h0000_0000,
    max_iterations: 16'd64,
    fractal_mode:   MODE_MANDELBROT
  };

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   results_seen;
  int   pixels_sent = 0;
  int   quiet_cycles = 0;
  bit   in_burst = 1'b0;
  bit   out_burst = 1'b0;
  bit   hold_req = 1'b0;

  efti_in_if  in_if();
  efti_out_if out_if();
  efti_cfg_if cfg_if();

  escape_time_fractal_iterator uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_m (out_if),
    .cfg_s (cfg_if)
  );

  escape_time_fractal_iterator_checker escape_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_if        (in_if),
    .out_if       (out_if),
    .cfg_if       (cfg_if),
    .mismatches   (mismatches),
    .results_seen (results_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort if no channel moves a transaction for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = out_burst ? 0 : $urandom_range(0, 19);
      end
      if ($urandom_range(0, 23) == 0) out_burst = !out_burst;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  function automatic logic [COL_W-1:0] pick_coord();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return COL_W'($urandom);
    endcase
  endfunction

  function automatic cfg_t random_view(input view_kind_t kind);
    cfg_t        v;
    int unsigned roll;
    v.fractal_mode = 1'($urandom);
    v.julia_c_real = 32'(-268435456 + $urandom_range(0, 536870912));
    v.julia_c_imag = 32'(-268435456 + $urandom_range(0, 536870912));
    v.origin_real = 32'(-671088640 + $urandom_range(0, 939524096));
    v.top_imag = 32'(-402653184 + $urandom_range(0, 805306368));
    v.step_real = ($urandom_range(0, 2) == 0) ? 31'($urandom_range(0, 16384)) :
                                                31'($urandom_range(0, 1048576));
    v.step_imag = ($urandom_range(0, 2) == 0) ? 31'($urandom_range(0, 16384)) :
                                                31'($urandom_range(0, 1048576));
    roll = $urandom_range(0, 9);
    v.max_iterations = (roll == 0) ? 16'd0 :
                       (roll == 1) ? 16'($urandom_range(1, 3)) : 16'($urandom_range(4, 80));
    case (kind)
      VIEW_WILD: begin
        v.origin_real = $urandom;
        v.top_imag = $urandom;
        v.step_real = 31'($urandom);
        v.step_imag = 31'($urandom);
        v.julia_c_real = $urandom;
        v.julia_c_imag = $urandom;
        v.max_iterations = 16'($urandom_range(0, 40));
      end
      VIEW_OUTSIDE: begin
        // every point starts at radius 3 or more, so a huge limit stays cheap
        v.origin_real = 32'h3000_0000 + 32'($urandom_range(0, 32'h0FFF_FFFF));
        v.max_iterations = 16'($urandom_range(32768, 65535));
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.pixel_col <= col;
    in_if.pixel_row <= row;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Hold the input until every outstanding pixel has returned
  task automatic drain();
    if (results_seen != pixels_sent) begin
      in_if.valid <= 1'b0;
      while (results_seen != pixels_sent) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic load_view(input cfg_t v, input bit stray);
    drain();
    write_reg(REG_ORIGIN_REAL, v.origin_real);
    write_reg(REG_TOP_IMAG, v.top_imag);
    write_reg(REG_STEP_REAL, {1'($urandom), v.step_real});
    write_reg(REG_STEP_IMAG, {1'($urandom), v.step_imag});
    write_reg(REG_JULIA_C_REAL, v.julia_c_real);
    write_reg(REG_JULIA_C_IMAG, v.julia_c_imag);
    write_reg(REG_MAX_ITERATIONS, {16'($urandom), v.max_iterations});
    write_reg(REG_FRACTAL_MODE, {31'($urandom), v.fractal_mode});
    // an index past the register file must leave everything untouched
    if (stray || $urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(8, 255)), $urandom);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    cfg_t        view;
    int          phase_no;
    int          phase_len;
    int unsigned pick;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.pixel_col <= '0;
    in_if.pixel_row <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset view: corners, exact radius two, origin, cusp, alternating bits
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(1023, 0);
    send_pixel(0, 1023);
    send_pixel(512, 512);
    send_pixel(0, 512);
    send_pixel(512, 0);
    send_pixel(576, 512);
    send_pixel(341, 682);

    // zero limit
    view = HOME_VIEW;
    view.max_iterations = '0;
    load_view(view, 1'b0);
    send_pixel(0, 0);
    send_pixel(512, 512);
    send_pixel(0, 512);

    // escape on the only allowed iteration, and the origin reaching that limit
    view.max_iterations = 16'd1;
    load_view(view, 1'b0);
    send_pixel(512, 0);
    send_pixel(512, 512);

    // mapped coordinates saturate
    view.origin_real = 32'sh8000_0000;
    view.top_imag = 32'sh7FFF_FFFF;
    view.step_real = '1;
    view.step_imag = '1;
    view.max_iterations = 16'd10;
    load_view(view, 1'b0);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(1, 1);
    send_pixel(0, 1023);
    send_pixel(1023, 0);

    // Julia with extreme constant, iterates saturate
    view = HOME_VIEW;
    view.fractal_mode = MODE_JULIA;
    view.julia_c_real = 32'sh8000_0000;
    view.julia_c_imag = 32'sh7FFF_FFFF;
    view.max_iterations = '1;
    load_view(view, 1'b1);
    send_pixel(512, 512);
    send_pixel(600, 400);
    send_pixel(0, 0);

    // full limit on a point that never escapes and on one that escapes after a single iteration
    view = HOME_VIEW;
    view.max_iterations = '1;
    load_view(view, 1'b0);
    send_pixel(512, 512);
    send_pixel(1023, 512);

    phase_no = 0;
    while (pixels_sent < TOTAL_PIXELS) begin
      pick = $urandom_range(0, 7);
      view = random_view((pick == 0) ? VIEW_WILD : (pick == 1) ? VIEW_OUTSIDE : VIEW_ZOOM);
      load_view(view, 1'b0);
      in_burst = ($urandom_range(0, 3) == 0);
      // keep offering pixels while results back up
      if (phase_no == 1 || phase_no == 8) begin
        hold_req = 1'b1;
        in_burst = 1'b1;
      end
      phase_len = $urandom_range(15, 60);
      repeat (phase_len) begin
        if ($urandom_range(0, 39) == 0) drain();
        send_pixel(pick_coord(), ROW_W'(pick_coord()));
      end
      phase_no++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
